### rtl/lpmd_pkg.sv
// Package for the length-prefixed message deframer.
// Holds the parse phase, result kind and result word types used by the parser and the top level.
// No dependencies.
package lpmd_pkg;

    typedef enum logic [5:0] {
        PH_FLAG = 6'b000001,
        PH_LEN0 = 6'b000010,
        PH_LEN1 = 6'b000100,
        PH_LEN2 = 6'b001000,
        PH_LEN3 = 6'b010000,
        PH_DATA = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    localparam int LEN_W = 32;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

### rtl/lpmd_in_stage.sv
// Input register of the deframer.
// Holds one accepted byte until the parse stage consumes it; depends on nothing.
module lpmd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign byte_ready = !valid_reg || advance;
    assign valid_next = byte_ready ? byte_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

### rtl/lpmd_parse.sv
// Frame parser of the deframer: phase and length counter, one byte per step.
// Depends on lpmd_pkg.
module lpmd_parse
    import lpmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] cur_byte,
    output res_t       res
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEN_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   rem_next;
    logic [LEN_W-1:0]   rem_dec;
    logic [LEN_W-1:0]   len_full;

    assign rem_dec  = rem_reg - LEN_W'(1);
    assign len_full = {rem_reg[LEN_W-1:8], cur_byte};

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        res        = '{valid: 1'b0, kind: KIND_PAYLOAD, data: 8'd0, last: 1'b0};
        unique case (phase_reg)
            PH_LEN0:
            begin
                rem_next   = {cur_byte, 24'd0};
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                rem_next   = {rem_reg[31:24], cur_byte, 16'd0};
                phase_next = PH_LEN2;
            end
            PH_LEN2:
            begin
                rem_next   = {rem_reg[31:16], cur_byte, 8'd0};
                phase_next = PH_LEN3;
            end
            PH_LEN3:
            begin
                rem_next = len_full;
                if (len_full == '0)
                begin
                    phase_next = PH_FLAG;
                    res = '{valid: 1'b1, kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_FLAG;
                end
                res = '{valid: 1'b1, kind: KIND_PAYLOAD, data: cur_byte,
                        last: (rem_dec == '0)};
            end
            default:
            begin
                if (cur_byte != 8'd0)
                begin
                    phase_next = PH_FLAG;
                    res = '{valid: 1'b1, kind: KIND_ERROR, data: cur_byte, last: 1'b0};
                end
                else
                begin
                    phase_next = PH_LEN0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            rem_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

### rtl/length_prefixed_message_deframer_unit.sv
// Length-prefixed message deframer, top level. Takes one byte per cycle while the
// output is free and recovers frames of a zero flag byte, a 32-bit big-endian
// length and that many payload bytes. Each byte is registered in the input
// stage, parsed combinationally and its result, if any, lands in an output
// register; a new byte is taken every cycle while results are drained.
// Payload bytes come out with kind 0 and last_of_message on the final byte, a zero
// length gives one kind 1 result with last set, and a nonzero flag byte gives a
// kind 2 result carrying that byte, after which the next byte is a fresh flag.
// Depends on lpmd_pkg, lpmd_in_stage and lpmd_parse.
module length_prefixed_message_deframer_unit
    import lpmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] in_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       last_of_message
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_free;
    logic       advance;
    res_t       res;
    logic       out_valid_reg;
    logic       out_valid_next;
    kind_t      kind_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign out_free = !out_valid_reg || result_ready;
    assign advance  = held_valid && out_free;

    lpmd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .in_byte    (in_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    lpmd_parse u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (held_byte),
        .res      (res)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = res.valid;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            last_reg <= res.last;
        end
    end

    assign result_valid    = out_valid_reg;
    assign out_kind        = 2'(kind_reg);
    assign out_byte        = data_reg;
    assign last_of_message = last_reg;

endmodule
